[rtl/kbc_pkg.sv]
// kbc_pkg: shared codes and helpers for the keyboard bus controller.
// Word kinds, register addresses, frame constants and the tone prescaler mask.
// No dependencies.
`default_nettype none

package kbc_pkg;

   localparam int KindWidth = 3;
   localparam int AddrWidth = 2;
   localparam int ByteWidth = 8;
   localparam int BitCountWidth = 4;
   localparam int PrescaleWidth = 10;
   localparam int SelectWidth = 3;

   localparam logic [KindWidth-1:0] KIND_TICK  = 3'd0;
   localparam logic [KindWidth-1:0] KIND_FALL  = 3'd1;
   localparam logic [KindWidth-1:0] KIND_RISE  = 3'd2;
   localparam logic [KindWidth-1:0] KIND_READ  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_WRITE = 3'd4;

   localparam logic [AddrWidth-1:0] ADDR_KEY     = 2'd0;
   localparam logic [AddrWidth-1:0] ADDR_SCRATCH = 2'd1;
   localparam logic [AddrWidth-1:0] ADDR_SELECT  = 2'd2;
   localparam logic [AddrWidth-1:0] ADDR_COMPARE = 2'd3;

   localparam logic [BitCountWidth-1:0] FIRST_DATA_BIT = 4'd1;
   localparam logic [BitCountWidth-1:0] LAST_DATA_BIT  = 4'd8;
   localparam logic [BitCountWidth-1:0] FRAME_BITS     = 4'd11;

   localparam logic [SelectWidth-1:0] SEL_STOP    = 3'd0;
   localparam logic [SelectWidth-1:0] SEL_DIV1    = 3'd1;
   localparam logic [SelectWidth-1:0] SEL_DIV8    = 3'd2;
   localparam logic [SelectWidth-1:0] SEL_DIV64   = 3'd3;
   localparam logic [SelectWidth-1:0] SEL_DIV256  = 3'd4;
   localparam logic [SelectWidth-1:0] SEL_DIV1024 = 3'd5;

   function automatic logic [PrescaleWidth-1:0] prescale_mask(
      input logic [SelectWidth-1:0] sel
   );
      logic [PrescaleWidth-1:0] mask;
      begin
         unique case (sel)
            SEL_DIV8:    mask = 10'h007;
            SEL_DIV64:   mask = 10'h03F;
            SEL_DIV256:  mask = 10'h0FF;
            SEL_DIV1024: mask = 10'h3FF;
            default:     mask = '0;
         endcase
         return mask;
      end
   endfunction

   function automatic logic timer_running(input logic [SelectWidth-1:0] sel);
      begin
         return (sel >= SEL_DIV1) && (sel <= SEL_DIV1024);
      end
   endfunction

endpackage

`default_nettype wire

[rtl/keyboard_bus_controller.sv]
// keyboard_bus_controller: PS/2 receiver, host register file and tone timer.
// Order: an accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; an input register and a result register frame the
// single update stage, and the input side stalls only while a result is held.
// Reset (synchronous, active high): clears the valid bits of both stages and resets all controller state.
// Depends on kbc_pkg.
`default_nettype none

module keyboard_bus_controller
   import kbc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [KindWidth-1:0] req_kind,
   input  wire logic                 req_ps2_data,
   input  wire logic [AddrWidth-1:0] req_bus_address,
   input  wire logic [ByteWidth-1:0] req_write_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [ByteWidth-1:0] rsp_read_data,
   output      logic                 rsp_speaker
);

   // input stage
   logic                 in_valid_ff, in_valid_in;
   logic [KindWidth-1:0] kind_ff;
   logic                 ps2_data_ff;
   logic [AddrWidth-1:0] addr_ff;
   logic [ByteWidth-1:0] wdata_ff;

   // result stage
   logic                 out_valid_ff, out_valid_in;
   logic [ByteWidth-1:0] read_data_ff, read_data_in;
   logic                 speaker_ff;

   // controller state
   logic [ByteWidth-1:0]     shift_buffer_ff, shift_buffer_in;
   logic [BitCountWidth-1:0] bit_count_ff, bit_count_in;
   logic                     expect_falling_ff, expect_falling_in;
   logic [ByteWidth-1:0]     key_byte_ff, key_byte_in;
   logic [ByteWidth-1:0]     scratch_ff, scratch_in;
   logic [SelectWidth-1:0]   select_ff, select_in;
   logic [ByteWidth-1:0]     compare_ff, compare_in;
   logic [PrescaleWidth-1:0] prescale_ff, prescale_in;
   logic [ByteWidth-1:0]     timer_ff, timer_in;
   logic                     speaker_level_ff, speaker_level_in;

   logic                     advance;
   logic                     move;
   logic                     accept;
   logic [PrescaleWidth-1:0] prescale_next;
   logic [BitCountWidth-1:0] bit_count_next;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = move || (out_valid_ff && rsp_stall);

   assign prescale_next  = prescale_ff + PrescaleWidth'(1);
   assign bit_count_next = bit_count_ff + BitCountWidth'(1);

   always_comb begin
      shift_buffer_in   = shift_buffer_ff;
      bit_count_in      = bit_count_ff;
      expect_falling_in = expect_falling_ff;
      key_byte_in       = key_byte_ff;
      scratch_in        = scratch_ff;
      select_in         = select_ff;
      compare_in        = compare_ff;
      prescale_in       = prescale_ff;
      timer_in          = timer_ff;
      speaker_level_in  = speaker_level_ff;
      read_data_in      = '0;
      if (move) begin
         unique case (kind_ff)
            KIND_TICK: begin
               if (timer_running(select_ff)) begin
                  prescale_in = prescale_next;
                  if ((prescale_next & prescale_mask(select_ff)) == '0) begin
                     if (timer_ff == compare_ff) begin
                        timer_in         = '0;
                        speaker_level_in = !speaker_level_ff;
                     end else begin
                        timer_in = timer_ff + ByteWidth'(1);
                     end
                  end
               end
            end
            KIND_FALL: begin
               if (expect_falling_ff) begin
                  if (bit_count_ff >= FIRST_DATA_BIT && bit_count_ff <= LAST_DATA_BIT) begin
                     shift_buffer_in = {ps2_data_ff, shift_buffer_ff[ByteWidth-1:1]};
                  end
                  expect_falling_in = 1'b0;
               end
            end
            KIND_RISE: begin
               if (!expect_falling_ff) begin
                  if (bit_count_next == FRAME_BITS) begin
                     key_byte_in     = shift_buffer_ff;
                     shift_buffer_in = '0;
                     bit_count_in    = '0;
                  end else begin
                     bit_count_in = bit_count_next;
                  end
                  expect_falling_in = 1'b1;
               end
            end
            KIND_READ: begin
               unique case (addr_ff)
                  ADDR_KEY:     read_data_in = key_byte_ff;
                  ADDR_SCRATCH: read_data_in = scratch_ff;
                  default:      read_data_in = '0;
               endcase
            end
            KIND_WRITE: begin
               unique case (addr_ff)
                  ADDR_SCRATCH: scratch_in = wdata_ff;
                  ADDR_SELECT:  select_in  = wdata_ff[SelectWidth-1:0];
                  ADDR_COMPARE: compare_in = wdata_ff;
                  default:      ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         shift_buffer_ff   <= '0;
         bit_count_ff      <= '0;
         expect_falling_ff <= 1'b1;
         key_byte_ff       <= '0;
         scratch_ff        <= '0;
         select_ff         <= SEL_STOP;
         compare_ff        <= '0;
         prescale_ff       <= '0;
         timer_ff          <= '0;
         speaker_level_ff  <= 1'b0;
      end else begin
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
         shift_buffer_ff   <= shift_buffer_in;
         bit_count_ff      <= bit_count_in;
         expect_falling_ff <= expect_falling_in;
         key_byte_ff       <= key_byte_in;
         scratch_ff        <= scratch_in;
         select_ff         <= select_in;
         compare_ff        <= compare_in;
         prescale_ff       <= prescale_in;
         timer_ff          <= timer_in;
         speaker_level_ff  <= speaker_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_kind;
         ps2_data_ff <= req_ps2_data;
         addr_ff     <= req_bus_address;
         wdata_ff    <= req_write_data;
      end
      if (move) begin
         read_data_ff <= read_data_in;
         speaker_ff   <= speaker_level_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_speaker   = speaker_ff;

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff < FRAME_BITS)
      else $error("bit count past frame length");

   a_buffer_clear_at_frame_start: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff == '0 |-> shift_buffer_ff == '0)
      else $error("shift buffer not clear at frame start");

   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      move && kind_ff != KIND_READ |=> rsp_read_data == '0)
      else $error("nonzero read data for a non-read word");

   a_speaker_on_tick: assert property (@(posedge clock) disable iff (reset)
      speaker_level_ff != speaker_level_in |-> move && kind_ff == KIND_TICK)
      else $error("speaker toggled outside a tick");

   a_result_tracks_level: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_speaker == speaker_level_ff)
      else $error("result speaker differs from state");

endmodule

`default_nettype wire
